/* sv/tile_sprite_strip_pixel_renderer_assert.svh */
// assertion macros for the strip renderer
`ifndef TILE_SPRITE_STRIP_PIXEL_RENDERER_ASSERT_SVH
`define TILE_SPRITE_STRIP_PIXEL_RENDERER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TSSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tssr assertion failed");

// next-cycle implication
`define TSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tssr assertion failed");

`else

`define TSSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TSSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/tssr_pkg.sv */
package tssr_pkg;

    localparam int ROM_DEPTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int COLOR_DEPTH_DEF   = 32;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 8;
    localparam int PAL_W   = 6;
    localparam int COORD_W = 10;
    localparam int CHAN_W  = 8;

    localparam int PIX_PER_STRIP = 32;
    localparam int IDX_W         = $clog2(PIX_PER_STRIP);
    localparam int BYTE_IDX_W    = 3;
    localparam int PIX_IDX_W     = 2;
    localparam int STRIP_LAST    = PIX_PER_STRIP - 1;
    localparam int STRIP_TOP_OFS = 7;

    // sprite coordinate offsets when mirrored
    localparam int SPR_X_FLIP_OFS = 7;
    localparam int SPR_Y_FLIP_OFS = 5;

    // resistor weights
    localparam logic [CHAN_W-1:0] W_LO      = 8'h21;
    localparam logic [CHAN_W-1:0] W_MID     = 8'h47;
    localparam logic [CHAN_W-1:0] W_HI      = 8'h97;
    localparam logic [CHAN_W-1:0] W_BLUE_LO = 8'h51;
    localparam logic [CHAN_W-1:0] W_BLUE_HI = 8'hae;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TILE    = 3'd0,
        CMD_LOAD_SPRITE  = 3'd1,
        CMD_LOAD_PALETTE = 3'd2,
        CMD_LOAD_COLOR   = 3'd3,
        CMD_DRAW_TILE    = 3'd4,
        CMD_DRAW_SPRITE  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROM,
        S_PAL,
        S_COL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic we_tile;
        logic we_sprite;
        logic we_pal;
        logic we_col;
        logic rd_rom;
        logic rd_pal;
        logic rd_col;
    } t_tbl_ctrl;

endpackage

/* sv/tssr_in_if.sv */
interface tssr_in_if;
    import tssr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [ADDR_W-1:0]         addr;
    logic [DATA_W-1:0]         data;
    logic [PAL_W-1:0]          palette;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic                      flip_x;
    logic                      flip_y;

    modport source (
        output valid, cmd, addr, data, palette, start_x, start_y, flip_x, flip_y,
        input  ready
    );

    modport sink (
        input  valid, cmd, addr, data, palette, start_x, start_y, flip_x, flip_y,
        output ready
    );
endinterface

/* sv/tssr_out_if.sv */
interface tssr_out_if;
    import tssr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic                      visible;
    logic                      last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, visible, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, visible, last_pixel,
        output ready
    );
endinterface

/* sv/tssr_tables.sv */
module tssr_tables #(
    parameter int  ROM_DEPTH     = tssr_pkg::ROM_DEPTH_DEF,
    parameter int  PALETTE_DEPTH = tssr_pkg::PALETTE_DEPTH_DEF,
    parameter int  COLOR_DEPTH   = tssr_pkg::COLOR_DEPTH_DEF,
    localparam int RAW           = $clog2(ROM_DEPTH),
    localparam int PAW           = $clog2(PALETTE_DEPTH),
    localparam int CAW           = $clog2(COLOR_DEPTH)
) (
    input  logic                          i_clk,
    input  tssr_pkg::t_tbl_ctrl           i_ctrl,
    input  logic [tssr_pkg::ADDR_W-1:0]   i_wr_addr,
    input  logic [tssr_pkg::DATA_W-1:0]   i_wr_data,
    input  logic                          i_sprite,
    input  logic [RAW-1:0]                i_rom_raddr,
    input  logic [PAW-1:0]                i_pal_raddr,
    input  logic [CAW-1:0]                i_col_raddr,
    output logic [tssr_pkg::DATA_W-1:0]   o_rom_q,
    output logic [tssr_pkg::DATA_W-1:0]   o_pal_q,
    output logic [tssr_pkg::DATA_W-1:0]   o_col_q
);
    import tssr_pkg::*;

    logic [DATA_W-1:0] r_tile_mem   [ROM_DEPTH];
    logic [DATA_W-1:0] r_sprite_mem [ROM_DEPTH];
    logic [DATA_W-1:0] r_pal_mem    [PALETTE_DEPTH];
    logic [DATA_W-1:0] r_col_mem    [COLOR_DEPTH];

    logic [DATA_W-1:0] r_tile_q;
    logic [DATA_W-1:0] r_sprite_q;
    logic [DATA_W-1:0] r_pal_q;
    logic [DATA_W-1:0] r_col_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_tile) begin
            r_tile_mem[RAW'(i_wr_addr)] <= i_wr_data;
        end
        if (i_ctrl.rd_rom) begin
            r_tile_q <= r_tile_mem[i_rom_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_sprite) begin
            r_sprite_mem[RAW'(i_wr_addr)] <= i_wr_data;
        end
        if (i_ctrl.rd_rom) begin
            r_sprite_q <= r_sprite_mem[i_rom_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_pal) begin
            r_pal_mem[PAW'(i_wr_addr)] <= i_wr_data;
        end
        if (i_ctrl.rd_pal) begin
            r_pal_q <= r_pal_mem[i_pal_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we_col) begin
            r_col_mem[CAW'(i_wr_addr)] <= i_wr_data;
        end
        if (i_ctrl.rd_col) begin
            r_col_q <= r_col_mem[i_col_raddr];
        end
    end

    assign o_rom_q = i_sprite ? r_sprite_q : r_tile_q;
    assign o_pal_q = r_pal_q;
    assign o_col_q = r_col_q;
endmodule

/* sv/tssr_pix_unit.sv */
module tssr_pix_unit (
    input  logic [tssr_pkg::BYTE_IDX_W-1:0]    i_byte_idx,
    input  logic [tssr_pkg::PIX_IDX_W-1:0]     i_pix_idx,
    input  logic                               i_sprite,
    input  logic                               i_flip_x,
    input  logic                               i_flip_y,
    input  logic signed [tssr_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [tssr_pkg::COORD_W-1:0] i_start_y,
    input  logic [tssr_pkg::DATA_W-1:0]        i_color,
    output logic signed [tssr_pkg::COORD_W-1:0] o_pixel_x,
    output logic signed [tssr_pkg::COORD_W-1:0] o_pixel_y,
    output logic [tssr_pkg::CHAN_W-1:0]        o_red,
    output logic [tssr_pkg::CHAN_W-1:0]        o_green,
    output logic [tssr_pkg::CHAN_W-1:0]        o_blue,
    output logic                               o_visible
);
    import tssr_pkg::*;

    logic [COORD_W-1:0] ofs_x;
    logic [COORD_W-1:0] ofs_y;

    always_comb begin
        if (i_sprite && i_flip_x) begin
            ofs_x = COORD_W'(SPR_X_FLIP_OFS) - COORD_W'(i_byte_idx);
        end else begin
            ofs_x = COORD_W'(i_byte_idx) + COORD_W'(i_sprite);
        end
        if (i_sprite && i_flip_y) begin
            ofs_y = COORD_W'(i_pix_idx) - COORD_W'(SPR_Y_FLIP_OFS);
        end else begin
            // rows go upward from the anchor
            ofs_y = COORD_W'(0) - COORD_W'(i_pix_idx) - COORD_W'(1'b1);
        end
    end

    assign o_pixel_x = i_start_x + ofs_x;
    assign o_pixel_y = i_start_y + ofs_y;

    assign o_red   = ({CHAN_W{i_color[0]}} & W_LO) + ({CHAN_W{i_color[1]}} & W_MID)
                   + ({CHAN_W{i_color[2]}} & W_HI);
    assign o_green = ({CHAN_W{i_color[3]}} & W_LO) + ({CHAN_W{i_color[4]}} & W_MID)
                   + ({CHAN_W{i_color[5]}} & W_HI);
    assign o_blue  = ({CHAN_W{i_color[6]}} & W_BLUE_LO)
                   + ({CHAN_W{i_color[7]}} & W_BLUE_HI);
    assign o_visible = |i_color;
endmodule

/* sv/tile_sprite_strip_pixel_renderer.sv */
// load items give no beat; the block is ready again next cycle
// draw items: after accept S_ROM, S_PAL, S_COL, then the first pixel beat in S_EMIT
// later pixels rerun S_PAL and S_COL, a new byte S_ROM first; a stall holds S_EMIT
// a palette and a color read per pixel, plus a rom read per byte, set the pixel rate
// reset: synchronous active-low, returns the sequencer to idle; table contents are kept
// input is not ready while reset is held
`include "tile_sprite_strip_pixel_renderer_assert.svh"

module tile_sprite_strip_pixel_renderer #(
    parameter int  ROM_DEPTH     = tssr_pkg::ROM_DEPTH_DEF,
    parameter int  PALETTE_DEPTH = tssr_pkg::PALETTE_DEPTH_DEF,
    parameter int  COLOR_DEPTH   = tssr_pkg::COLOR_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tssr_in_if.sink    i_in,
    tssr_out_if.source o_out
);
    import tssr_pkg::*;

    localparam int RAW = $clog2(ROM_DEPTH);
    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int CAW = $clog2(COLOR_DEPTH);

    t_state                r_state;
    t_state                n_state;
    logic [RAW-1:0]        r_rom_addr;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_sprite;
    logic                  r_flip_x;
    logic                  r_flip_y;
    logic [PAL_W-1:0]      r_pal;
    logic [COORD_W-1:0]    r_sx;
    logic [COORD_W-1:0]    r_sy;

    t_tbl_ctrl             ctrl;
    logic                  in_fire;
    logic                  out_fire;
    logic                  is_draw;
    logic                  last_idx;
    logic                  byte_done;
    logic [DATA_W-1:0]     rom_q;
    logic [DATA_W-1:0]     pal_q;
    logic [DATA_W-1:0]     col_q;
    logic [PIX_IDX_W-1:0]  pix;
    logic [PIX_IDX_W-1:0]  z;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_fire  = o_out.valid && o_out.ready;
    assign is_draw   = i_in.cmd inside {CMD_DRAW_TILE, CMD_DRAW_SPRITE};
    assign last_idx  = (r_idx == IDX_W'(STRIP_LAST));
    assign z         = r_idx[PIX_IDX_W-1:0];
    assign byte_done = &z;
    // 2-bit pixel: bit z low, bit 4+z high
    assign pix       = {rom_q[z + 3'd4], rom_q[z]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && is_draw) begin
                    n_state = S_ROM;
                end
            end
            S_ROM:  n_state = S_PAL;
            S_PAL:  n_state = S_COL;
            S_COL:  n_state = S_EMIT;
            S_EMIT: begin
                if (o_out.ready) begin
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else if (byte_done) begin
                        n_state = S_ROM;
                    end else begin
                        n_state = S_PAL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_in.ready     = (r_state == S_IDLE) && i_rst_n;
        o_out.valid    = (r_state == S_EMIT);
        ctrl.we_tile   = in_fire && (i_in.cmd == CMD_LOAD_TILE);
        ctrl.we_sprite = in_fire && (i_in.cmd == CMD_LOAD_SPRITE);
        ctrl.we_pal    = in_fire && (i_in.cmd == CMD_LOAD_PALETTE);
        ctrl.we_col    = in_fire && (i_in.cmd == CMD_LOAD_COLOR);
        ctrl.rd_rom    = (r_state == S_ROM);
        ctrl.rd_pal    = (r_state == S_PAL);
        ctrl.rd_col    = (r_state == S_COL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && is_draw) begin
            // walk starts at the top byte of the strip
            r_rom_addr <= RAW'(i_in.addr) + RAW'(STRIP_TOP_OFS);
            r_idx      <= '0;
            r_sprite   <= (i_in.cmd == CMD_DRAW_SPRITE);
            r_flip_x   <= i_in.flip_x;
            r_flip_y   <= i_in.flip_y;
            r_pal      <= i_in.palette;
            r_sx       <= i_in.start_x;
            r_sy       <= i_in.start_y;
        end else if (out_fire) begin
            r_idx <= r_idx + IDX_W'(1);
            if (byte_done) begin
                r_rom_addr <= r_rom_addr - RAW'(1);
            end
        end
    end

    tssr_tables #(
        .ROM_DEPTH     (ROM_DEPTH),
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .COLOR_DEPTH   (COLOR_DEPTH)
    ) u_tables (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_wr_addr   (i_in.addr),
        .i_wr_data   (i_in.data),
        .i_sprite    (r_sprite),
        .i_rom_raddr (r_rom_addr),
        .i_pal_raddr (PAW'({r_pal, pix})),
        .i_col_raddr (CAW'(pal_q)),
        .o_rom_q     (rom_q),
        .o_pal_q     (pal_q),
        .o_col_q     (col_q)
    );

    tssr_pix_unit u_pix (
        .i_byte_idx (r_idx[IDX_W-1:PIX_IDX_W]),
        .i_pix_idx  (z),
        .i_sprite   (r_sprite),
        .i_flip_x   (r_flip_x),
        .i_flip_y   (r_flip_y),
        .i_start_x  (r_sx),
        .i_start_y  (r_sy),
        .i_color    (col_q),
        .o_pixel_x  (o_out.pixel_x),
        .o_pixel_y  (o_out.pixel_y),
        .o_red      (o_out.red),
        .o_green    (o_out.green),
        .o_blue     (o_out.blue),
        .o_visible  (o_out.visible)
    );

    assign o_out.last_pixel = last_idx;

    `TSSR_ASSERT_NOW(a_no_accept_while_busy, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `TSSR_ASSERT_NEXT(a_draw_starts_fetch, i_clk, i_rst_n, in_fire && is_draw,
        r_state == S_ROM && r_idx == '0)
    `TSSR_ASSERT_NEXT(a_last_ends_strip, i_clk, i_rst_n, out_fire && o_out.last_pixel,
        r_state == S_IDLE)
    `TSSR_ASSERT_NEXT(a_stall_holds_idx, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        $stable(r_idx) && $stable(r_rom_addr))
endmodule
